// ----- design/vtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vtpd_pkg: shared types and constants of the vertex transform core
// Transaction payloads, register map size and matrix reset values.
// ----------------------------------------------------------------------------
package vtpd_pkg;

    localparam int FIELD_W   = 32;
    localparam int ELEM_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int NUM_LANES = 3;
    localparam int NUM_ROWS  = 4;

    localparam logic FUNC_POINT = 1'b0;
    localparam logic FUNC_DIR   = 1'b1;

    typedef struct packed {
        logic                       func;
        logic signed [FIELD_W-1:0]  x_in;
        logic signed [FIELD_W-1:0]  y_in;
        logic signed [FIELD_W-1:0]  z_in;
    } t_vtx_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  x_out;
        logic signed [FIELD_W-1:0]  y_out;
        logic signed [FIELD_W-1:0]  z_out;
        logic                       w_zero;
        logic                       saturated;
    } t_vtx_out;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_mat;

    // identity matrix, Q16.16 diagonal
    localparam t_mat MAT_RESET = '{
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

endpackage

// ----- design/vtpd_xform.sv -----
// ----------------------------------------------------------------------------
// vtpd_xform: matrix times vector, three register stages
// Products, pair sums, then the full row sum with floor shift.
// ----------------------------------------------------------------------------
module vtpd_xform #(
    parameter int FRAC_BITS = 16,
    parameter int VEC_W     = 32,
    parameter int ROW_W     = 50
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_point,
    input  logic signed [VEC_W-1:0]           i_vec [vtpd_pkg::NUM_ROWS],
    input  vtpd_pkg::t_mat                    i_mat,
    output logic                              o_valid,
    output logic                              o_point,
    output logic signed [ROW_W-1:0]           o_row [vtpd_pkg::NUM_ROWS]
);

    localparam int PRW = vtpd_pkg::ELEM_W + VEC_W;
    localparam int SW1 = PRW + 1;
    localparam int SW2 = PRW + 2;

    logic signed [vtpd_pkg::ELEM_W-1:0] m [vtpd_pkg::NUM_ROWS][vtpd_pkg::NUM_ROWS];

    logic                  r_vld_a, r_vld_b;
    logic                  r_pt_a, r_pt_b;
    logic signed [PRW-1:0] r_prod [vtpd_pkg::NUM_ROWS][vtpd_pkg::NUM_ROWS];
    logic signed [SW1-1:0] r_pair [vtpd_pkg::NUM_ROWS][2];
    logic signed [SW1-1:0] n_pair [vtpd_pkg::NUM_ROWS][2];
    logic signed [ROW_W-1:0] n_row [vtpd_pkg::NUM_ROWS];
    logic signed [SW2-1:0] full   [vtpd_pkg::NUM_ROWS];

    // element (col c, row r) lives in register 2c + r/2, half r%2
    always_comb begin
        for (int c = 0; c < vtpd_pkg::NUM_ROWS; c++) begin
            for (int r = 0; r < vtpd_pkg::NUM_ROWS; r++) begin
                m[r][c] = i_mat[c*2 + r/2][(r%2)*vtpd_pkg::ELEM_W +: vtpd_pkg::ELEM_W];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < vtpd_pkg::NUM_ROWS; r++) begin
            n_pair[r][0] = SW1'(r_prod[r][0]) + SW1'(r_prod[r][1]);
            n_pair[r][1] = SW1'(r_prod[r][2]) + SW1'(r_prod[r][3]);
            full[r]      = SW2'(r_pair[r][0]) + SW2'(r_pair[r][1]);
            n_row[r]     = ROW_W'(full[r] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            o_valid <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt_a  <= i_point;
        r_pt_b  <= r_pt_a;
        o_point <= r_pt_b;
        for (int r = 0; r < vtpd_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < vtpd_pkg::NUM_ROWS; c++) begin
                r_prod[r][c] <= PRW'(m[r][c]) * PRW'(i_vec[c]);
            end
            r_pair[r] <= n_pair[r];
            o_row[r]  <= n_row[r];
        end
    end

endmodule

// ----- design/vtpd_div.sv -----
// ----------------------------------------------------------------------------
// vtpd_div: pipelined restoring divider, three lanes sharing one divisor
// Computes floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtpd_div #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32,
    parameter int DEN_W       = 50
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [DEN_W-1:0]       i_num [vtpd_pkg::NUM_LANES],
    input  logic [DEN_W-1:0]       i_den,
    output logic                   o_valid,
    output logic [COORD_WIDTH:0]   o_quo [vtpd_pkg::NUM_LANES],
    output logic                   o_ovf [vtpd_pkg::NUM_LANES]
);

    localparam int QW   = COORD_WIDTH + 1;
    localparam int NW   = DEN_W + FRAC_BITS;
    localparam int CMPW = NW + QW;

    logic             r_vld [QW+1];
    logic [DEN_W-1:0] r_den [QW+1];
    logic [DEN_W-1:0] r_rem [QW+1][vtpd_pkg::NUM_LANES];
    logic [QW-1:0]    r_low [QW+1][vtpd_pkg::NUM_LANES];
    logic [QW-1:0]    r_quo [QW+1][vtpd_pkg::NUM_LANES];
    logic             r_ovf [QW+1][vtpd_pkg::NUM_LANES];

    logic [NW-1:0]    dvd [vtpd_pkg::NUM_LANES];

    // entry stage: quotient too wide to fit QW bits is flagged here
    always_comb begin
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            dvd[l] = {i_num[l], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            r_ovf[0][l] <= CMPW'(dvd[l]) >= (CMPW'(i_den) << QW);
            r_rem[0][l] <= DEN_W'(dvd[l] >> QW);
            r_low[0][l] <= dvd[l][QW-1:0];
            r_quo[0][l] <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [DEN_W:0]   t   [vtpd_pkg::NUM_LANES];
        logic             ge  [vtpd_pkg::NUM_LANES];
        logic [DEN_W-1:0] nr  [vtpd_pkg::NUM_LANES];

        always_comb begin
            for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
                t[l]  = {r_rem[s][l], r_low[s][l][QW-1-s]};
                ge[l] = t[l] >= {1'b0, r_den[s]};
                nr[l] = ge[l] ? DEN_W'(t[l] - {1'b0, r_den[s]}) : DEN_W'(t[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
                r_rem[s+1][l] <= nr[l];
                r_low[s+1][l] <= r_low[s][l];
                r_quo[s+1][l] <= {r_quo[s][l][QW-2:0], ge[l]};
                r_ovf[s+1][l] <= r_ovf[s][l];
            end
        end
    end

    assign o_valid = r_vld[QW];
    always_comb begin
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            o_quo[l] = r_quo[QW][l];
            o_ovf[l] = r_ovf[QW][l];
        end
    end

endmodule

// ----- design/vertex_transform_perspective_divide_core.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_core: 4x4 transform with w divide
// Multiplies a fixed-point vector by the configured matrix; w divides points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_data and raise start; the transaction is taken at
//   the clock edge where start is high and busy is low. busy stays low, so
//   one vertex can enter every cycle.
//   Output channel: o_done pulses for one cycle with o_result. Results leave
//   in input order, exactly one per transaction.
//   Config: write the matrix through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the pipe is empty; a write takes effect at the next edge.
// Stages from accept to o_done: input register, transform stages, prep stage,
//   divider entry and step stages, one quotient bit per step, output register.
// Throughput: one transaction per cycle.
// Reset: clears all valid bits and loads the identity matrix. The receiver
//   cannot stall, so the pipe never holds.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_core #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  vtpd_pkg::t_vtx_in                    i_data,
    output logic                                 o_done,
    output vtpd_pkg::t_vtx_out                   o_result,
    input  logic                                 i_cfg_we,
    input  logic [vtpd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vtpd_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int VEC_W   = (COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2;
    localparam int ROW_W   = vtpd_pkg::ELEM_W + VEC_W + 2 - FRAC_BITS;
    localparam int QW      = COORD_WIDTH + 1;
    localparam int DIV_LAT = QW + 1;
    localparam logic [ROW_W-1:0] EPS = ROW_W'((64'd1 << FRAC_BITS) / 64'd1000000);
    localparam logic signed [ROW_W-1:0] R_MAX = {{(ROW_W-COORD_WIDTH+1){1'b0}},
                                                 {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ROW_W-1:0] R_MIN = {{(ROW_W-COORD_WIDTH+1){1'b1}},
                                                 {(COORD_WIDTH-1){1'b0}}};
    localparam logic [QW-1:0] Q_MAXP = {2'b00, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [QW-1:0] Q_MAXN = {2'b01, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                                   wz;
        logic                                   do_div;
        logic [vtpd_pkg::NUM_LANES-1:0]         neg;
        logic [vtpd_pkg::NUM_LANES-1:0][ROW_W-1:0] row;
    } t_byp;

    // matrix registers
    vtpd_pkg::t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= vtpd_pkg::MAT_RESET;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    // input register: take low COORD_WIDTH bits, sign-extend, append w
    logic                    accept;
    logic                    r_in_vld;
    logic                    r_in_pt;
    logic signed [VEC_W-1:0] r_vec [vtpd_pkg::NUM_ROWS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_pt  <= (i_data.func == vtpd_pkg::FUNC_POINT);
        r_vec[0] <= VEC_W'(signed'(i_data.x_in[COORD_WIDTH-1:0]));
        r_vec[1] <= VEC_W'(signed'(i_data.y_in[COORD_WIDTH-1:0]));
        r_vec[2] <= VEC_W'(signed'(i_data.z_in[COORD_WIDTH-1:0]));
        r_vec[3] <= (i_data.func == vtpd_pkg::FUNC_POINT) ? (VEC_W'(1) << FRAC_BITS) : '0;
    end

    // matrix multiply
    logic                    xf_vld;
    logic                    xf_pt;
    logic signed [ROW_W-1:0] xf_row [vtpd_pkg::NUM_ROWS];

    vtpd_xform #(
        .FRAC_BITS (FRAC_BITS),
        .VEC_W     (VEC_W),
        .ROW_W     (ROW_W)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_point (r_in_pt),
        .i_vec   (r_vec),
        .i_mat   (r_mat),
        .o_valid (xf_vld),
        .o_point (xf_pt),
        .o_row   (xf_row)
    );

    // prep stage: magnitudes, quotient signs, near-zero w test
    logic             r_p_vld;
    logic [ROW_W-1:0] r_p_num [vtpd_pkg::NUM_LANES];
    logic [ROW_W-1:0] r_p_den;
    t_byp             r_p_byp;
    logic [ROW_W-1:0] aw;
    logic [ROW_W-1:0] an [vtpd_pkg::NUM_LANES];
    logic             wz;

    always_comb begin
        aw = xf_row[3][ROW_W-1] ? ROW_W'(-xf_row[3]) : ROW_W'(xf_row[3]);
        wz = xf_pt && (aw <= EPS);
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            an[l] = xf_row[l][ROW_W-1] ? ROW_W'(-xf_row[l]) : ROW_W'(xf_row[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= xf_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_den        <= aw;
        r_p_byp.wz     <= wz;
        r_p_byp.do_div <= xf_pt && !wz;
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            r_p_num[l]     <= an[l];
            r_p_byp.neg[l] <= xf_row[l][ROW_W-1] ^ xf_row[3][ROW_W-1];
            r_p_byp.row[l] <= xf_row[l];
        end
    end

    // divider and the bypass line that runs beside it
    logic          dv_vld;
    logic [QW-1:0] dv_quo [vtpd_pkg::NUM_LANES];
    logic          dv_ovf [vtpd_pkg::NUM_LANES];
    t_byp          r_byp  [DIV_LAT];

    vtpd_div #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH),
        .DEN_W       (ROW_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf)
    );

    always_ff @(posedge i_clk) begin
        r_byp[0] <= r_p_byp;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_byp[k] <= r_byp[k-1];
        end
    end

    // final stage: pick divided or plain value, clamp, flag
    t_byp                          fb;
    logic signed [ROW_W-1:0]       rv;
    logic signed [COORD_WIDTH-1:0] cv  [vtpd_pkg::NUM_LANES];
    logic                          sat [vtpd_pkg::NUM_LANES];

    always_comb begin
        fb = r_byp[DIV_LAT-1];
        for (int l = 0; l < vtpd_pkg::NUM_LANES; l++) begin
            rv = signed'(fb.row[l]);
            if (fb.do_div) begin
                sat[l] = dv_ovf[l] || (fb.neg[l] ? (dv_quo[l] > Q_MAXN)
                                                 : (dv_quo[l] > Q_MAXP));
                if (sat[l]) begin
                    cv[l] = fb.neg[l] ? COORD_WIDTH'(R_MIN) : COORD_WIDTH'(R_MAX);
                end else begin
                    cv[l] = fb.neg[l] ? COORD_WIDTH'(~dv_quo[l] + 1'b1)
                                      : COORD_WIDTH'(dv_quo[l]);
                end
            end else begin
                sat[l] = (rv > R_MAX) || (rv < R_MIN);
                if (rv > R_MAX) begin
                    cv[l] = COORD_WIDTH'(R_MAX);
                end else if (rv < R_MIN) begin
                    cv[l] = COORD_WIDTH'(R_MIN);
                end else begin
                    cv[l] = COORD_WIDTH'(rv);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.x_out     <= vtpd_pkg::FIELD_W'(cv[0]);
        o_result.y_out     <= vtpd_pkg::FIELD_W'(cv[1]);
        o_result.z_out     <= vtpd_pkg::FIELD_W'(cv[2]);
        o_result.w_zero    <= fb.wz;
        o_result.saturated <= sat[0] || sat[1] || sat[2];
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the vertex transform / perspective divide core
// Streams points and directions in bursts through several matrix settings,
// predicts each result in wide integer arithmetic and compares every field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vtpd_pkg::*;

    localparam int FRAC       = 16;
    localparam int SETTLE_CYC = 4;     // quiet cycles before a matrix write
    localparam int DRAIN_CYC  = 60;    // idle wait after the last result is checked
    localparam int WDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_vtx_in              vtx;
    } t_job;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_vtx_in              i_data;
    logic                 o_done;
    t_vtx_out             o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    vertex_transform_perspective_divide_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_data     (i_data),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // job list filled up front, vertex results still in flight
    t_job     job_q[$];
    t_vtx_out vertex_q[$];
    t_mat     shadow_mat;     // matrix as the core should hold it
    int       n_sent;         // vertices accepted
    int       n_seen;         // results checked
    int       drv_errs;
    int       mon_errs;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [127:0] mat_elem(t_mat m, int col, int row);
        logic [CFG_W-1:0]         r;
        logic signed [ELEM_W-1:0] h;
        r = m[col * 2 + row / 2];
        h = (row % 2) ? r[63:32] : r[31:0];
        return h;
    endfunction

    // exact dot product of one matrix row, floor-shifted back to Q16.16
    function automatic logic signed [127:0] row_dot(t_mat m, int row,
                                                   logic signed [127:0] v[4]);
        logic signed [127:0] acc;
        acc = 0;
        for (int c = 0; c < 4; c++) acc += mat_elem(m, c, row) * v[c];
        return acc >>> FRAC;
    endfunction

    // (n << FRAC) / d, truncated toward zero
    function automatic logic signed [127:0] q_div(logic signed [127:0] n,
                                                 logic signed [127:0] d);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = (an << FRAC) / ad;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_vtx_out transform_vertex(t_mat m, t_vtx_in a);
        logic signed [127:0] v[4];
        logic signed [127:0] r[3];
        logic signed [127:0] w;
        logic signed [31:0]  o[3];
        t_vtx_out            res;
        bit                  point;
        point = (a.func == FUNC_POINT);
        v[0] = a.x_in;
        v[1] = a.y_in;
        v[2] = a.z_in;
        v[3] = point ? (128'sd1 <<< FRAC) : 128'sd0;
        for (int i = 0; i < 3; i++) r[i] = row_dot(m, i, v);
        res.w_zero    = 1'b0;
        res.saturated = 1'b0;
        if (point) begin
            w = row_dot(m, 3, v);
            // epsilon is below one LSB in Q16.16, so only exact zero counts
            if (w == 0) begin
                res.w_zero = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) r[i] = q_div(r[i], w);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r[i] > 128'sh7FFF_FFFF) begin
                o[i] = 32'sh7FFF_FFFF;
                res.saturated = 1'b1;
            end else if (r[i] < -128'sh8000_0000) begin
                o[i] = 32'sh8000_0000;
                res.saturated = 1'b1;
            end else begin
                o[i] = r[i][31:0];
            end
        end
        res.x_out = o[0];
        res.y_out = o[1];
        res.z_out = o[2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_vertex(logic f, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
        t_job j;
        j.is_cfg = 0;
        j.idx    = '0;
        j.data   = '0;
        j.vtx    = '{func: f, x_in: x, y_in: y, z_in: z};
        job_q.push_back(j);
    endfunction

    // queue all eight register writes of a matrix
    function automatic void load_matrix(t_mat m);
        t_job j;
        for (int i = 0; i < NUM_REGS; i++) begin
            j.is_cfg = 1;
            j.idx    = i[CFG_IDX_W-1:0];
            j.data   = m[i];
            j.vtx    = '0;
            job_q.push_back(j);
        end
    endfunction

    function automatic t_mat put_elem(t_mat m, int col, int row, logic [31:0] val);
        if (row % 2) m[col * 2 + row / 2][63:32] = val;
        else         m[col * 2 + row / 2][31:0]  = val;
        return m;
    endfunction

    // mostly modest Q16.16 values so the divide stays in range, some full-range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2:    return $urandom;
            3:          return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4:          return '0;
            default:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0:          return $urandom;
            1:          return '0;
            2:          return ONE_Q16;
            default:    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Job list: directed phases first, then random matrices and vertices
    // ------------------------------------------------------------------------
    initial begin
        t_mat m;

        // identity from reset: x and y at their extremes, both modes
        add_vertex(FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        add_vertex(FUNC_DIR,   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_vertex(FUNC_POINT, 32'hFFFF_FFFF, ONE_Q16,       32'h0000_0001);
        add_vertex(FUNC_DIR,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        // perspective: w takes z, so z == 0 leaves w zero, tiny z overflows
        m = '0;
        m = put_elem(m, 0, 0, ONE_Q16);
        m = put_elem(m, 1, 1, ONE_Q16);
        m = put_elem(m, 2, 2, ONE_Q16);
        m = put_elem(m, 2, 3, ONE_Q16);
        load_matrix(m);
        add_vertex(FUNC_POINT, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_0000);
        add_vertex(FUNC_POINT, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000);
        add_vertex(FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        add_vertex(FUNC_POINT, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        add_vertex(FUNC_DIR,   32'h0001_0000, 32'h0005_0000, 32'h0000_0000);
        add_vertex(FUNC_POINT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

        // scale by two plus translation, w of one: clamping of large results
        m = '0;
        m = put_elem(m, 0, 0, 32'h0002_0000);
        m = put_elem(m, 1, 1, 32'h0002_0000);
        m = put_elem(m, 2, 2, 32'h0002_0000);
        m = put_elem(m, 3, 0, 32'h0010_0000);
        m = put_elem(m, 3, 3, ONE_Q16);
        load_matrix(m);
        add_vertex(FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
        add_vertex(FUNC_DIR,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1234);
        add_vertex(FUNC_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);

        // extreme matrices: all most positive, then all most negative
        load_matrix({NUM_REGS{64'h7FFF_FFFF_7FFF_FFFF}});
        add_vertex(FUNC_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vertex(FUNC_DIR,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_vertex(FUNC_POINT, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        load_matrix({NUM_REGS{64'h8000_0000_8000_0000}});
        add_vertex(FUNC_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_vertex(FUNC_DIR,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);

        // zero matrix: every point hits w zero
        load_matrix('0);
        add_vertex(FUNC_POINT, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
        add_vertex(FUNC_DIR,   32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);

        // random phases: new matrix each, every third perspective, identity last
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < NUM_REGS; i++) m[i] = {rand_elem(), rand_elem()};
            if (p % 3 == 0) m = put_elem(m, 2, 3, ONE_Q16);
            if (p == 7) m = MAT_RESET;
            load_matrix(m);
            for (int k = 0; k < 100; k++)
                add_vertex($urandom_range(0, 3) == 0 ? FUNC_DIR : FUNC_POINT,
                           rand_coord(), rand_coord(), rand_coord());
        end

        // hold until every job is out and every result has been checked
        wait (job_q.size() == 0);
        @(posedge i_clk);
        while (start || n_sent != n_seen) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (drv_errs == 0 && mon_errs == 0 && vertex_q.size() == 0) begin
            $display("vertex_transform_perspective_divide_core verification clean");
        end else begin
            $display("vertex_transform_perspective_divide_core verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of vertices with random gaps; matrix writes only when the
    // pipe is empty and quiet_cnt has reached SETTLE_CYC. Next values are worked
    // out first and each port gets a single nonblocking assignment per edge.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;
    int quiet_cnt;

    always @(posedge i_clk) begin
        logic     nxt_start;
        logic     nxt_we;
        t_job     j;
        t_vtx_in  nxt_data;
        logic [CFG_IDX_W-1:0] nxt_idx;
        logic [CFG_W-1:0]     nxt_cfg;
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_data     <= '0;
            i_cfg_we   <= 1'b0;
            i_cfg_idx  <= '0;
            i_cfg_data <= '0;
            shadow_mat  = MAT_RESET;
            n_sent     <= 0;
            drv_errs    = 0;
            burst_left  = $urandom_range(1, 20);
            gap_left    = 0;
            quiet_cnt   = 0;
        end else begin
            nxt_start = start;
            nxt_we    = 1'b0;
            nxt_data  = i_data;
            nxt_idx   = i_cfg_idx;
            nxt_cfg   = i_cfg_data;

            // record the transaction taken at this edge
            if (start && !busy) begin
                vertex_q.push_back(transform_vertex(shadow_mat, i_data));
                n_sent   <= n_sent + 1;
                nxt_start = 1'b0;
            end

            quiet_cnt = (!start && !i_cfg_we && n_sent == n_seen) ? quiet_cnt + 1 : 0;

            // advance to the next job unless a vertex is still being offered
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_q.size() > 0) begin
                    if (job_q[0].is_cfg) begin
                        if (quiet_cnt >= SETTLE_CYC) begin
                            j       = job_q.pop_front();
                            nxt_we  = 1'b1;
                            nxt_idx = j.idx;
                            nxt_cfg = j.data;
                            shadow_mat[j.idx] = j.data;
                        end
                    end else begin
                        j         = job_q.pop_front();
                        nxt_start = 1'b1;
                        nxt_data  = j.vtx;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 6);
                        end
                    end
                end
            end

            start      <= nxt_start;
            i_data     <= nxt_data;
            i_cfg_we   <= nxt_we;
            i_cfg_idx  <= nxt_idx;
            i_cfg_data <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each strobed result must match the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_vtx_out want;
        if (!i_rst_n) begin
            n_seen  <= 0;
            mon_errs = 0;
        end else if (o_done) begin
            n_seen <= n_seen + 1;
            if (vertex_q.size() == 0) begin
                $error("result with no transaction outstanding: %h", o_result);
                mon_errs++;
            end else begin
                want = vertex_q.pop_front();
                if (o_result.x_out !== want.x_out) begin
                    $error("x_out expected %h actual %h", want.x_out, o_result.x_out);
                    mon_errs++;
                end
                if (o_result.y_out !== want.y_out) begin
                    $error("y_out expected %h actual %h", want.y_out, o_result.y_out);
                    mon_errs++;
                end
                if (o_result.z_out !== want.z_out) begin
                    $error("z_out expected %h actual %h", want.z_out, o_result.z_out);
                    mon_errs++;
                end
                if (o_result.w_zero !== want.w_zero) begin
                    $error("w_zero expected %b actual %b", want.w_zero, o_result.w_zero);
                    mon_errs++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $error("saturated expected %b actual %b",
                           want.saturated, o_result.saturated);
                    mon_errs++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop the run if nothing moves for too long
    // ------------------------------------------------------------------------
    int stall_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WDOG_LIMIT) begin
            $display("vertex_transform_perspective_divide_core verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

endmodule

// ----- vertex_transform_perspective_divide_core.f -----
design/vtpd_pkg.sv
design/vtpd_xform.sv
design/vtpd_div.sv
design/vertex_transform_perspective_divide_core.sv
tb/tb.sv
